// ===== rtl/perlin_noise_3d_macros.svh =====
// Assertion macros shared by the perlin noise checker
`ifndef PERLIN_NOISE_3D_MACROS_SVH
`define PERLIN_NOISE_3D_MACROS_SVH

// check a property outside reset
`define PN3_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("perlin_noise_3d check failed");

// check a property that must also hold across reset
`define PN3_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("perlin_noise_3d reset check failed");

`endif

// ===== rtl/pn3_pkg.sv =====
// Types and constants of the perlin noise block
`timescale 1ns / 1ps
package pn3_pkg;
  localparam int TABLE_DEPTH = 512;
  localparam int TAB_AW      = 9;
  localparam int HASH_W      = 8;
  localparam int OUT_W       = 18;
  localparam int OUT_FRAC    = 16;
  localparam int OUT_MAX_I   = 131071;
  localparam int OUT_MIN_I   = -131072;
  localparam int CMD_Q_DEPTH = 4;
  localparam int OUT_Q_DEPTH = 16;
  localparam int CRED_W      = 5;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_EVAL = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    VSEL_X = 2'd0,
    VSEL_Y = 2'd1,
    VSEL_Z = 2'd2
  } vsel_t;

  typedef struct packed {
    logic  u_is_y;
    vsel_t v_sel;
    logic  neg_u;
    logic  neg_v;
  } grad_sel_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } front_q_t;

  function automatic grad_sel_t grad_pick(input logic [3:0] h);
    grad_sel_t s;
    s.u_is_y = (h >= 4'd8);
    if (h < 4'd4) begin
      s.v_sel = VSEL_Y;
    end else if (h == 4'd12 || h == 4'd14) begin
      s.v_sel = VSEL_X;
    end else begin
      s.v_sel = VSEL_Z;
    end
    s.neg_u = h[0];
    s.neg_v = h[1];
    return s;
  endfunction
endpackage

// ===== rtl/pn3_ram.sv =====
// Generic single write port RAM with registered read
`timescale 1ns / 1ps
module pn3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/pn3_fifo.sv =====
// Small first-in first-out queue with push/full and pop/empty sides
`timescale 1ns / 1ps
module pn3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp_r];

  always_comb begin
    wp_nxt  = do_push ? AW'(wp_r + 1'b1) : wp_r;
    rp_nxt  = do_pop ? AW'(rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= wdata;
    end
  end
endmodule

// ===== rtl/pn3_front.sv =====
// Front end: accept items, split coordinates, queue them for the back end
`timescale 1ns / 1ps
module pn3_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_kind,
  input  logic [8:0]            in_table_index,
  input  logic [7:0]            in_table_value,
  input  logic signed [31:0]    in_coord_x,
  input  logic signed [31:0]    in_coord_y,
  input  logic signed [31:0]    in_coord_z,
  output pn3_pkg::front_q_t     q_ctl,
  input  logic                  q_pop,
  output logic [8:0]            q_idx,
  output logic [7:0]            q_val,
  output logic [7:0]            q_xi,
  output logic [7:0]            q_yi,
  output logic [7:0]            q_zi,
  output logic [FRAC_BITS-1:0]  q_tx,
  output logic [FRAC_BITS-1:0]  q_ty,
  output logic [FRAC_BITS-1:0]  q_tz
);
  import pn3_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int QW = 1 + TAB_AW + HASH_W + 3*8 + 3*F;

  logic [QW-1:0] wdata, rdata;
  logic          empty;
  logic          kind_bit;

  assign wdata = {in_kind, in_table_index, in_table_value,
                  in_coord_x[F+7:F], in_coord_y[F+7:F], in_coord_z[F+7:F],
                  in_coord_x[F-1:0], in_coord_y[F-1:0], in_coord_z[F-1:0]};

  pn3_fifo #(.WIDTH(QW), .DEPTH(CMD_Q_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .full  (in_full),
    .wdata (wdata),
    .pop   (q_pop),
    .empty (empty),
    .rdata (rdata)
  );

  assign {kind_bit, q_idx, q_val, q_xi, q_yi, q_zi, q_tx, q_ty, q_tz} = rdata;
  assign q_ctl.valid = !empty;
  assign q_ctl.kind  = kind_t'(kind_bit);
endmodule

// ===== rtl/pn3_back.sv =====
// Back end: table lookups, fade, gradients, trilinear blend, result queue
`timescale 1ns / 1ps
module pn3_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pn3_pkg::front_q_t           q_ctl,
  output logic                        q_pop,
  input  logic [8:0]                  q_idx,
  input  logic [7:0]                  q_val,
  input  logic [7:0]                  q_xi,
  input  logic [7:0]                  q_yi,
  input  logic [7:0]                  q_zi,
  input  logic [FRAC_BITS-1:0]        q_tx,
  input  logic [FRAC_BITS-1:0]        q_ty,
  input  logic [FRAC_BITS-1:0]        q_tz,
  input  logic                        out_pop,
  output logic                        out_empty,
  output logic signed [pn3_pkg::OUT_W-1:0] out_noise_value
);
  import pn3_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int W   = F + 4;
  localparam int PW  = 2 * W;
  localparam int RW  = W + 9;
  localparam int SH  = (F > OUT_FRAC) ? (F - OUT_FRAC) : 1;
  localparam int SL  = (F < OUT_FRAC) ? (OUT_FRAC - F) : 0;
  localparam logic [W-1:0]  ONE_U  = W'(1) << F;
  localparam logic [W-1:0]  ONE15  = W'(15) << F;
  localparam logic [W-1:0]  ONE10  = W'(10) << F;
  localparam logic [PW-1:0] HALF_P = PW'(1) << (F - 1);
  localparam logic signed [RW-1:0] SAT_HI = RW'(OUT_MAX_I);
  localparam logic signed [RW-1:0] SAT_LO = RW'(OUT_MIN_I);

  function automatic logic [W-1:0] uround(input logic [PW-1:0] p);
    logic [PW-1:0] s;
    s = p + HALF_P;
    return W'(s >> F);
  endfunction

  function automatic logic signed [W-1:0] sround(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p + $signed(HALF_P);
    return W'(s >>> F);
  endfunction

  // issue and credit
  logic               issue, ld0, ev0, out_take;
  logic [CRED_W-1:0]  cred_r, cred_nxt;

  assign issue    = q_ctl.valid &&
                    (q_ctl.kind == KIND_LOAD || cred_r < CRED_W'(OUT_Q_DEPTH));
  assign q_pop    = issue;
  assign ld0      = issue && (q_ctl.kind == KIND_LOAD);
  assign ev0      = issue && (q_ctl.kind == KIND_EVAL);
  assign out_take = out_pop && !out_empty;

  always_comb begin
    cred_nxt = cred_r + CRED_W'(ev0) - CRED_W'(out_take);
  end

  // pipeline control
  logic       v1_r, v2_r, e3_r, e4_r, e5_r, e6_r, e7_r, e8_r, e9_r, e10_r;
  kind_t      k1_r, k2_r;
  logic [8:0] idx1_r, idx2_r;
  logic [7:0] val1_r, val2_r;
  logic [7:0] y1_r, z1_r, z2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      e3_r   <= 1'b0;
      e4_r   <= 1'b0;
      e5_r   <= 1'b0;
      e6_r   <= 1'b0;
      e7_r   <= 1'b0;
      e8_r   <= 1'b0;
      e9_r   <= 1'b0;
      e10_r  <= 1'b0;
    end else begin
      cred_r <= cred_nxt;
      v1_r   <= issue;
      v2_r   <= v1_r;
      e3_r   <= v2_r && (k2_r == KIND_EVAL);
      e4_r   <= e3_r;
      e5_r   <= e4_r;
      e6_r   <= e5_r;
      e7_r   <= e6_r;
      e8_r   <= e7_r;
      e9_r   <= e8_r;
      e10_r  <= e9_r;
    end
  end

  always_ff @(posedge clk) begin
    k1_r   <= q_ctl.kind;
    idx1_r <= q_idx;
    val1_r <= q_val;
    y1_r   <= q_yi;
    z1_r   <= q_zi;
    k2_r   <= k1_r;
    idx2_r <= idx1_r;
    val2_r <= val1_r;
    z2_r   <= z1_r;
  end

  // permutation table copies, one per lookup, written as a load passes
  logic [7:0] rd1 [2];
  logic [7:0] rd2 [4];
  logic [7:0] rd3 [8];
  logic       we2, we3;

  assign we2 = v1_r && (k1_r == KIND_LOAD);
  assign we3 = v2_r && (k2_r == KIND_LOAD);

  for (genvar m = 0; m < 2; m++) begin : g_lvl1
    pn3_ram #(.WIDTH(HASH_W), .DEPTH(TABLE_DEPTH)) u_ram (
      .clk   (clk),
      .we    (ld0),
      .waddr (q_idx),
      .wdata (q_val),
      .raddr ({1'b0, q_xi} + TAB_AW'(m)),
      .rdata (rd1[m])
    );
  end

  for (genvar k = 0; k < 4; k++) begin : g_lvl2
    localparam int SIDE = k % 2;
    localparam int INC  = k / 2;
    pn3_ram #(.WIDTH(HASH_W), .DEPTH(TABLE_DEPTH)) u_ram (
      .clk   (clk),
      .we    (we2),
      .waddr (idx1_r),
      .wdata (val1_r),
      .raddr ({1'b0, rd1[SIDE]} + {1'b0, y1_r} + TAB_AW'(INC)),
      .rdata (rd2[k])
    );
  end

  for (genvar i = 0; i < 8; i++) begin : g_lvl3
    localparam int SRC = i % 4;
    localparam int INC = i / 4;
    pn3_ram #(.WIDTH(HASH_W), .DEPTH(TABLE_DEPTH)) u_ram (
      .clk   (clk),
      .we    (we3),
      .waddr (idx2_r),
      .wdata (val2_r),
      .raddr ({1'b0, rd2[SRC]} + {1'b0, z2_r} + TAB_AW'(INC)),
      .rdata (rd3[i])
    );
  end

  // fade per axis
  logic [F-1:0]         t0 [3];
  logic [F-1:0]         t1_r [3];
  logic [F-1:0]         t2_r [3];
  logic [F-1:0]         t3_r [3];
  logic [PW-1:0]        ptg_r [3];
  logic [PW-1:0]        ptt_r [3];
  logic [W-1:0]         b2_r [3];
  logic [W-1:0]         b3_r [3];
  logic [PW-1:0]        pct_r [3];
  logic [W-1:0]         d3_r [3];
  logic [PW-1:0]        pdb_r [3];
  logic signed [W-1:0]  fd4 [3];

  assign t0[0] = q_tx;
  assign t0[1] = q_ty;
  assign t0[2] = q_tz;

  for (genvar a = 0; a < 3; a++) begin : g_fade
    logic [W-1:0] tw0, gg, cc;
    assign tw0 = W'(t0[a]);
    assign gg  = ONE15 - W'(6) * tw0;
    assign cc  = uround(ptt_r[a]);
    assign fd4[a] = $signed(uround(pdb_r[a]));

    always_ff @(posedge clk) begin
      t1_r[a]  <= t0[a];
      t2_r[a]  <= t1_r[a];
      t3_r[a]  <= t2_r[a];
      ptg_r[a] <= PW'(tw0) * PW'(gg);
      ptt_r[a] <= PW'(tw0) * PW'(tw0);
      b2_r[a]  <= ONE10 - uround(ptg_r[a]);
      pct_r[a] <= PW'(cc) * PW'(t1_r[a]);
      b3_r[a]  <= b2_r[a];
      d3_r[a]  <= uround(pct_r[a]);
      pdb_r[a] <= PW'(d3_r[a]) * PW'(b3_r[a]);
    end
  end

  // corner gradients
  logic signed [W-1:0] g4_r [8];

  for (genvar i = 0; i < 8; i++) begin : g_grad
    localparam int OX = i % 2;
    localparam int OY = (i / 2) % 2;
    localparam int OZ = i / 4;
    grad_sel_t           sel;
    logic signed [W-1:0] cx, cy, cz, uu, vv, su, sv;

    assign sel = grad_pick(rd3[i][3:0]);
    assign cx  = $signed(W'(t3_r[0])) - $signed(OX != 0 ? ONE_U : W'(0));
    assign cy  = $signed(W'(t3_r[1])) - $signed(OY != 0 ? ONE_U : W'(0));
    assign cz  = $signed(W'(t3_r[2])) - $signed(OZ != 0 ? ONE_U : W'(0));

    always_comb begin
      uu = sel.u_is_y ? cy : cx;
      case (sel.v_sel)
        VSEL_X:  vv = cx;
        VSEL_Y:  vv = cy;
        VSEL_Z:  vv = cz;
        default: vv = cz;
      endcase
      su = sel.neg_u ? -uu : uu;
      sv = sel.neg_v ? -vv : vv;
    end

    always_ff @(posedge clk) begin
      g4_r[i] <= su + sv;
    end
  end

  // trilinear blend
  logic signed [PW-1:0] p5_r [4];
  logic signed [W-1:0]  a5_r [4];
  logic signed [W-1:0]  v5_r, w5_r, v6_r, w6_r, w7_r, w8_r;
  logic signed [W-1:0]  l6_r [4];
  logic signed [PW-1:0] p7_r [2];
  logic signed [W-1:0]  a7_r [2];
  logic signed [W-1:0]  m8_r [2];
  logic signed [PW-1:0] p9_r;
  logic signed [W-1:0]  a9_r, r9;
  logic signed [RW-1:0] r_sc, r_sat;
  logic signed [OUT_W-1:0] res10_r;

  for (genvar k = 0; k < 4; k++) begin : g_lerp_x
    always_ff @(posedge clk) begin
      p5_r[k] <= PW'(fd4[0]) * PW'(g4_r[2*k+1] - g4_r[2*k]);
      a5_r[k] <= g4_r[2*k];
      l6_r[k] <= a5_r[k] + sround(p5_r[k]);
    end
  end

  for (genvar j = 0; j < 2; j++) begin : g_lerp_y
    always_ff @(posedge clk) begin
      p7_r[j] <= PW'(v6_r) * PW'(l6_r[2*j+1] - l6_r[2*j]);
      a7_r[j] <= l6_r[2*j];
      m8_r[j] <= a7_r[j] + sround(p7_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    v5_r <= fd4[1];
    w5_r <= fd4[2];
    v6_r <= v5_r;
    w6_r <= w5_r;
    w7_r <= w6_r;
    w8_r <= w7_r;
    p9_r <= PW'(w8_r) * PW'(m8_r[1] - m8_r[0]);
    a9_r <= m8_r[0];
    res10_r <= r_sat[OUT_W-1:0];
  end

  assign r9 = a9_r + sround(p9_r);

  if (F > OUT_FRAC) begin : g_down
    assign r_sc = (RW'(r9) + (RW'(1) << (SH - 1))) >>> SH;
  end else if (F < OUT_FRAC) begin : g_up
    assign r_sc = RW'(r9) <<< SL;
  end else begin : g_same
    assign r_sc = RW'(r9);
  end

  always_comb begin
    if (r_sc > SAT_HI) begin
      r_sat = SAT_HI;
    end else if (r_sc < SAT_LO) begin
      r_sat = SAT_LO;
    end else begin
      r_sat = r_sc;
    end
  end

  pn3_fifo #(.WIDTH(OUT_W), .DEPTH(OUT_Q_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (e10_r),
    .full  (),
    .wdata (res10_r),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (out_noise_value)
  );
endmodule

// ===== rtl/perlin_noise_3d.sv =====
// Top level of the improved 3D Perlin noise evaluator
// Usage:
//   Input queue: drive in_* and raise in_push; the item transfers on a clock
//   edge with in_push high and in_full low. in_kind low loads one table entry
//   (in_table_index, in_table_value) and gives no result; in_kind high
//   evaluates noise at (in_coord_x, in_coord_y, in_coord_z).
//   Result queue: while out_empty is low, out_noise_value holds the oldest
//   result; it transfers on an edge with out_pop high.
//   Throughput: one item per cycle unless evaluations are stalled (see Stall), loads and evaluations mixed freely.
//   Path from input transfer to out_empty falling: command queue, issue,
//   three table lookup levels, fade and blend pipeline, result queue.
//   Fourteen table copies give each lookup its own read port.
//   Stall: the result queue holds 16 entries; evaluations wait in the
//   4-entry command queue once 16 results are queued or in flight, and
//   in_full rises when that queue fills.
//   Reset: synchronous, active low; both queues empty. Table contents are
//   undefined until loaded; load every entry an evaluation reads first.
`timescale 1ns / 1ps
module perlin_noise_3d #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_kind,
  input  logic [8:0]                  in_table_index,
  input  logic [7:0]                  in_table_value,
  input  logic signed [31:0]          in_coord_x,
  input  logic signed [31:0]          in_coord_y,
  input  logic signed [31:0]          in_coord_z,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic signed [pn3_pkg::OUT_W-1:0] out_noise_value
);
  import pn3_pkg::*;

  front_q_t               q_ctl;
  logic                   q_pop;
  logic [8:0]             q_idx;
  logic [7:0]             q_val, q_xi, q_yi, q_zi;
  logic [FRAC_BITS-1:0]   q_tx, q_ty, q_tz;

  pn3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_kind        (in_kind),
    .in_table_index (in_table_index),
    .in_table_value (in_table_value),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .q_ctl          (q_ctl),
    .q_pop          (q_pop),
    .q_idx          (q_idx),
    .q_val          (q_val),
    .q_xi           (q_xi),
    .q_yi           (q_yi),
    .q_zi           (q_zi),
    .q_tx           (q_tx),
    .q_ty           (q_ty),
    .q_tz           (q_tz)
  );

  pn3_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_ctl           (q_ctl),
    .q_pop           (q_pop),
    .q_idx           (q_idx),
    .q_val           (q_val),
    .q_xi            (q_xi),
    .q_yi            (q_yi),
    .q_zi            (q_zi),
    .q_tx            (q_tx),
    .q_ty            (q_ty),
    .q_tz            (q_tz),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_noise_value (out_noise_value)
  );
endmodule

// ===== rtl/pn3_checker.sv =====
// Port-level checks of the perlin noise block and their binding
`timescale 1ns / 1ps
`include "perlin_noise_3d_macros.svh"
module pn3_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_push,
  input logic                        in_full,
  input logic                        out_pop,
  input logic                        out_empty,
  input logic [pn3_pkg::OUT_W-1:0]   out_noise_value
);
  `PN3_ASSERT_RST(a_reset_clears, !rst_n |=> (out_empty && !in_full))
  `PN3_ASSERT(a_full_needs_push, $rose(in_full) |-> $past(in_push))
  `PN3_ASSERT(a_result_holds, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_noise_value)))
endmodule

bind perlin_noise_3d pn3_checker u_pn3_checker (.*);
